### src/pds_pkg.sv
// pds_pkg: widths, search limits, state codes and bundle types for the
// PLL divider search unit. No dependencies.
package pds_pkg;

  localparam int FREQ_W = 26;
  localparam int TGT_W  = 27;
  localparam int WIDE_W = 30;
  localparam int VCO_W  = 31;
  localparam int CNT_W  = 5;
  localparam int M_W    = 6;
  localparam int N_W    = 9;
  localparam int P_W    = 4;
  localparam int PC_W   = 2;
  localparam int Q_W    = 4;

  typedef logic [FREQ_W-1:0] freq_t;
  typedef logic [TGT_W-1:0]  tgt_t;
  typedef logic [WIDE_W-1:0] wide_t;
  typedef logic [VCO_W-1:0]  vco_t;

  localparam logic CFG_HSE = 1'b0;
  localparam logic CFG_HSI = 1'b1;

  localparam freq_t HSE_RESET = FREQ_W'(8000000);
  localparam freq_t HSI_RESET = FREQ_W'(16000000);

  localparam wide_t FIN_MIN   = WIDE_W'(950000);
  localparam wide_t FIN_MAX   = WIDE_W'(2100000);
  localparam vco_t  VCO_MIN   = VCO_W'(100000000);
  localparam vco_t  VCO_MAX   = VCO_W'(432000000);
  localparam tgt_t  TGT_MIN   = TGT_W'(24000000);
  localparam tgt_t  TGT_MAX   = TGT_W'(100000000);
  localparam vco_t  N_MIN     = VCO_W'(50);
  localparam vco_t  N_MAX     = VCO_W'(432);
  localparam vco_t  Q_STEP    = VCO_W'(48000001);

  localparam logic [M_W-1:0] M_FIRST = M_W'(2);
  localparam logic [M_W-1:0] M_LAST  = M_W'(63);
  localparam logic [Q_W-1:0] Q_FIRST = Q_W'(2);
  localparam logic [Q_W-1:0] Q_LAST  = Q_W'(15);
  localparam logic [PC_W-1:0] P_LAST = PC_W'(3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MSTART,
    ST_MWAIT,
    ST_PSTART,
    ST_PWAIT,
    ST_QINIT,
    ST_QSRCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic  start;
    wide_t dividend;
    freq_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    wide_t quot;
    freq_t rem;
  } div_rsp_t;

endpackage

### src/pds_if.sv
// pds_if: request and response channel interfaces (valid/ready plus payload).
// Depends on pds_pkg for field widths.
interface pds_req_if;
  logic                 valid;
  logic                 ready;
  logic                 source_is_hse;
  pds_pkg::tgt_t        target_frequency;

  modport source (output valid, source_is_hse, target_frequency, input ready);
  modport sink   (input valid, source_is_hse, target_frequency, output ready);
endinterface

interface pds_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [pds_pkg::M_W-1:0]     div_m;
  logic [pds_pkg::N_W-1:0]     mult_n;
  logic [pds_pkg::P_W-1:0]     div_p;
  logic [pds_pkg::PC_W-1:0]    p_code;
  logic [pds_pkg::Q_W-1:0]     div_q;

  modport source (output valid, found, div_m, mult_n, div_p, p_code, div_q, input ready);
  modport sink   (input valid, found, div_m, mult_n, div_p, p_code, div_q, output ready);
endinterface

### src/pll_divider_search_unit.sv
// pll_divider_search_unit: top level; oscillator registers, search sequencer
// and shared serial divider. Depends on pds_pkg, pds_if, pds_serial_div, pds_search_ctrl.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   source_is_hse, target_frequency
//   rsp      out  valid/ready   found, div_m, mult_n, div_p, p_code, div_q
//   cfg      in   cfg_we        cfg_index, cfg_data
//
// Every division (source/M, target*P/fin) runs on the one serial divider; each
// M costs one division, plus four more when source/M is in range, plus a Q scan.
// A target outside 24..100 MHz skips the search and goes straight to the result
// register. Requests are taken one at a time; a result waiting in the output
// register does not hold off the next request.
// Synchronous reset restores the oscillator registers and empties the output.
module pll_divider_search_unit (
  input  logic           clk,
  input  logic           rst,
  pds_req_if.sink        req,
  pds_rsp_if.source      rsp,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  pds_pkg::freq_t cfg_data
);

  pds_pkg::freq_t    hse_frequency;
  pds_pkg::freq_t    hsi_frequency;
  pds_pkg::div_req_t div_req;
  pds_pkg::div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      hse_frequency <= pds_pkg::HSE_RESET;
      hsi_frequency <= pds_pkg::HSI_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pds_pkg::CFG_HSE: hse_frequency <= cfg_data;
        pds_pkg::CFG_HSI: hsi_frequency <= cfg_data;
        default: ;
      endcase
    end
  end

  pds_search_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .hse_frequency (hse_frequency),
    .hsi_frequency (hsi_frequency),
    .req           (req),
    .rsp           (rsp),
    .div_req       (div_req),
    .div_rsp       (div_rsp)
  );

  pds_serial_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

### src/pds_serial_div.sv
// pds_serial_div: restoring divider, one quotient bit per cycle.
// Depends on pds_pkg (div_req_t, div_rsp_t).
module pds_serial_div (
  input  logic              clk,
  input  logic              rst,
  input  pds_pkg::div_req_t req,
  output pds_pkg::div_rsp_t rsp
);

  logic                       busy;
  logic                       done;
  logic [pds_pkg::CNT_W-1:0]  cnt;
  pds_pkg::wide_t             shreg;
  pds_pkg::freq_t             rem;
  pds_pkg::freq_t             dsr;

  logic [pds_pkg::FREQ_W:0]   trial;
  logic [pds_pkg::FREQ_W:0]   diff;
  logic                       qbit;
  pds_pkg::freq_t             rem_next;

  always_comb begin
    trial    = {rem, shreg[pds_pkg::WIDE_W-1]};
    diff     = trial - {1'b0, dsr};
    qbit     = (trial >= {1'b0, dsr});
    rem_next = qbit ? diff[pds_pkg::FREQ_W-1:0] : trial[pds_pkg::FREQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        shreg <= req.dividend;
        rem   <= '0;
        dsr   <= req.divisor;
      end else if (busy) begin
        shreg <= {shreg[pds_pkg::WIDE_W-2:0], qbit};
        rem   <= rem_next;
        cnt   <= cnt + 1'b1;
        if (cnt == pds_pkg::CNT_W'(pds_pkg::WIDE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = shreg;
  assign rsp.rem  = rem;

endmodule

### src/pds_search_ctrl.sv
// pds_search_ctrl: M/P search sequencer, Q scan and result register.
// Depends on pds_pkg, pds_req_if/pds_rsp_if; drives a pds_serial_div.
module pds_search_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  pds_pkg::freq_t    hse_frequency,
  input  pds_pkg::freq_t    hsi_frequency,
  pds_req_if.sink           req,
  pds_rsp_if.source         rsp,
  output pds_pkg::div_req_t div_req,
  input  pds_pkg::div_rsp_t div_rsp
);

  pds_pkg::state_t state, state_next;

  pds_pkg::freq_t              src;
  pds_pkg::tgt_t               target;
  logic [pds_pkg::M_W-1:0]     m;
  logic [pds_pkg::PC_W-1:0]    p_idx;
  pds_pkg::freq_t              fin;
  pds_pkg::wide_t              tp;
  logic                        best_valid;
  logic [pds_pkg::N_W-1:0]     best_n;
  logic [pds_pkg::PC_W-1:0]    best_p;
  pds_pkg::vco_t               best_vco;
  logic [pds_pkg::Q_W-1:0]     q;
  pds_pkg::vco_t               thr;
  logic                        res_found;

  logic                        out_valid;
  logic                        out_found;
  logic [pds_pkg::M_W-1:0]     out_m;
  logic [pds_pkg::N_W-1:0]     out_n;
  logic [pds_pkg::P_W-1:0]     out_p;
  logic [pds_pkg::PC_W-1:0]    out_pc;
  logic [pds_pkg::Q_W-1:0]     out_q;

  logic                        req_xfer;
  logic                        tgt_ok;
  logic                        fin_ok;
  pds_pkg::wide_t              tp_calc;
  pds_pkg::wide_t              t2;
  pds_pkg::wide_t              t4;
  logic                        rem_nz;
  pds_pkg::freq_t              slack;
  pds_pkg::vco_t               ncand;
  pds_pkg::vco_t               vco_c;
  logic                        cand_ok;
  logic                        cand_better;
  logic                        load_out;

  assign req.ready = (state == pds_pkg::ST_IDLE) && !rst;
  assign req_xfer  = req.valid && req.ready;
  assign tgt_ok    = (req.target_frequency >= pds_pkg::TGT_MIN) &&
                     (req.target_frequency <= pds_pkg::TGT_MAX);
  assign fin_ok    = (div_rsp.quot >= pds_pkg::FIN_MIN) && (div_rsp.quot <= pds_pkg::FIN_MAX);
  assign load_out  = (state == pds_pkg::ST_FINISH) && (!out_valid || rsp.ready);

  // target * P for P = 2, 4, 6, 8
  always_comb begin
    t2 = {2'b00, target, 1'b0};
    t4 = {1'b0, target, 2'b00};
    unique case (p_idx)
      2'd0:    tp_calc = t2;
      2'd1:    tp_calc = t4;
      2'd2:    tp_calc = t4 + t2;
      default: tp_calc = {target, 3'b000};
    endcase
  end

  // smallest N with fin*N >= target*P; it hits when fin*N - target*P < P and N and fin*N are in range
  always_comb begin
    rem_nz      = (div_rsp.rem != '0);
    slack       = fin - div_rsp.rem;
    ncand       = {1'b0, div_rsp.quot} + pds_pkg::VCO_W'(rem_nz);
    vco_c       = {1'b0, tp} + (rem_nz ? pds_pkg::VCO_W'(slack) : '0);
    cand_ok     = (ncand >= pds_pkg::N_MIN) && (ncand <= pds_pkg::N_MAX) &&
                  (vco_c >= pds_pkg::VCO_MIN) && (vco_c <= pds_pkg::VCO_MAX) &&
                  (!rem_nz || (slack <= pds_pkg::FREQ_W'({p_idx, 1'b1})));
    cand_better = cand_ok && (!best_valid || (ncand[pds_pkg::N_W-1:0] < best_n));
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = tp_calc;
    div_req.divisor  = fin;
    state_next       = state;
    unique case (state)
      pds_pkg::ST_IDLE: begin
        if (req_xfer) begin
          state_next = tgt_ok ? pds_pkg::ST_MSTART : pds_pkg::ST_FINISH;
        end
      end
      pds_pkg::ST_MSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = pds_pkg::WIDE_W'(src);
        div_req.divisor  = pds_pkg::FREQ_W'(m);
        state_next       = pds_pkg::ST_MWAIT;
      end
      pds_pkg::ST_MWAIT: begin
        if (div_rsp.done) begin
          priority if (fin_ok) state_next = pds_pkg::ST_PSTART;
          else if (m == pds_pkg::M_LAST) state_next = pds_pkg::ST_FINISH;
          else state_next = pds_pkg::ST_MSTART;
        end
      end
      pds_pkg::ST_PSTART: begin
        div_req.start = 1'b1;
        state_next    = pds_pkg::ST_PWAIT;
      end
      pds_pkg::ST_PWAIT: begin
        if (div_rsp.done) begin
          priority if (p_idx != pds_pkg::P_LAST) state_next = pds_pkg::ST_PSTART;
          else if (best_valid || cand_ok) state_next = pds_pkg::ST_QINIT;
          else if (m == pds_pkg::M_LAST) state_next = pds_pkg::ST_FINISH;
          else state_next = pds_pkg::ST_MSTART;
        end
      end
      pds_pkg::ST_QINIT: state_next = pds_pkg::ST_QSRCH;
      pds_pkg::ST_QSRCH: begin
        if ((best_vco < thr) || (q == pds_pkg::Q_LAST)) state_next = pds_pkg::ST_FINISH;
      end
      pds_pkg::ST_FINISH: begin
        if (load_out) state_next = pds_pkg::ST_IDLE;
      end
      default: state_next = pds_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pds_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
      res_found  <= 1'b0;
    end else begin
      unique case (state)
        pds_pkg::ST_IDLE: begin
          if (req_xfer) begin
            src       <= req.source_is_hse ? hse_frequency : hsi_frequency;
            target    <= req.target_frequency;
            m         <= pds_pkg::M_FIRST;
            res_found <= 1'b0;
          end
        end
        pds_pkg::ST_MWAIT: begin
          if (div_rsp.done) begin
            if (fin_ok) begin
              fin        <= div_rsp.quot[pds_pkg::FREQ_W-1:0];
              p_idx      <= '0;
              best_valid <= 1'b0;
            end else begin
              m <= m + 1'b1;
            end
          end
        end
        pds_pkg::ST_PSTART: tp <= tp_calc;
        pds_pkg::ST_PWAIT: begin
          if (div_rsp.done) begin
            if (cand_better) begin
              best_valid <= 1'b1;
              best_n     <= ncand[pds_pkg::N_W-1:0];
              best_p     <= p_idx;
              best_vco   <= vco_c;
            end
            p_idx <= p_idx + 1'b1;
            if ((p_idx == pds_pkg::P_LAST) && !(best_valid || cand_ok)) m <= m + 1'b1;
          end
        end
        pds_pkg::ST_QINIT: begin
          q   <= pds_pkg::Q_FIRST;
          thr <= pds_pkg::Q_STEP + pds_pkg::Q_STEP;
        end
        pds_pkg::ST_QSRCH: begin
          if (best_vco < thr) begin
            res_found <= 1'b1;
          end else begin
            q   <= q + 1'b1;
            thr <= thr + pds_pkg::Q_STEP;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found <= res_found;
      out_m     <= res_found ? m : '0;
      out_n     <= res_found ? best_n : '0;
      out_p     <= res_found ? ({1'b0, best_p, 1'b0} + pds_pkg::P_W'(2)) : '0;
      out_pc    <= res_found ? best_p : '0;
      out_q     <= res_found ? q : '0;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.found  = out_found;
  assign rsp.div_m  = out_m;
  assign rsp.mult_n = out_n;
  assign rsp.div_p  = out_p;
  assign rsp.p_code = out_pc;
  assign rsp.div_q  = out_q;

endmodule

### src/pds_checker.sv
// pds_checker: port-level assertions for pll_divider_search_unit, with bind.
// Depends on pds_pkg widths.
module pds_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic                       found,
  input logic [pds_pkg::M_W-1:0]    div_m,
  input logic [pds_pkg::N_W-1:0]    mult_n,
  input logic [pds_pkg::P_W-1:0]    div_p,
  input logic [pds_pkg::PC_W-1:0]   p_code,
  input logic [pds_pkg::Q_W-1:0]    div_q
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp valid dropped before transfer");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while search busy");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !found |-> (div_m == '0) && (mult_n == '0) && (div_p == '0) &&
                            (p_code == '0) && (div_q == '0))
    else $error("not-found result with nonzero dividers");

  a_hit_legal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && found |-> (div_m >= 6'd2) && (mult_n >= 9'd50) && (mult_n <= 9'd432) &&
                           (div_p == ({1'b0, p_code, 1'b0} + 4'd2)) && (div_q >= 4'd2))
    else $error("found result with illegal dividers");

endmodule

bind pll_divider_search_unit pds_checker u_pds_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .found     (rsp.found),
  .div_m     (rsp.div_m),
  .mult_n    (rsp.mult_n),
  .div_p     (rsp.div_p),
  .p_code    (rsp.p_code),
  .div_q     (rsp.div_q)
);

### verif/pds_search_checker.sv
// pds_search_checker: watches the request, response and register ports of the
// PLL divider search unit, predicts every divider set and compares it.
// Depends on pds_pkg and the pds_req_if / pds_rsp_if interfaces.
module pds_search_checker (
  input  logic           clk,
  input  logic           rst,
  pds_req_if             req,
  pds_rsp_if             rsp,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  pds_pkg::freq_t cfg_data,
  output int             fails,
  output int             pending
);

  localparam logic [63:0] REF_IN_LO  = 64'd950000;
  localparam logic [63:0] REF_IN_HI  = 64'd2100000;
  localparam logic [63:0] VCO_LO     = 64'd100000000;
  localparam logic [63:0] VCO_HI     = 64'd432000000;
  localparam logic [63:0] SYSCLK_LO  = 64'd24000000;
  localparam logic [63:0] SYSCLK_HI  = 64'd100000000;
  localparam logic [63:0] AUXCLK_MAX = 64'd48000000;

  typedef struct packed {
    logic                     found;
    logic [pds_pkg::M_W-1:0]  div_m;
    logic [pds_pkg::N_W-1:0]  mult_n;
    logic [pds_pkg::P_W-1:0]  div_p;
    logic [pds_pkg::PC_W-1:0] p_code;
    logic [pds_pkg::Q_W-1:0]  div_q;
  } pll_setting_t;

  pds_pkg::freq_t hse_hz;
  pds_pkg::freq_t hsi_hz;
  pll_setting_t   settings_due[$];
  int             mismatches;

  // first M, N, P, Q in search order that gives the target, else all zero
  function automatic pll_setting_t search_dividers(pds_pkg::freq_t osc_hz,
                                                   pds_pkg::tgt_t target);
    pll_setting_t s;
    logic [63:0]  ref_in;
    logic [63:0]  vco;
    logic [63:0]  sysclk;
    int           p_hit;
    int           q_hit;
    s = '0;
    if (target < SYSCLK_LO || target > SYSCLK_HI) return s;
    for (int m = 2; m < 64; m++) begin
      ref_in = osc_hz / m;
      if (ref_in < REF_IN_LO || ref_in > REF_IN_HI) continue;
      for (int n = 50; n < 433; n++) begin
        vco = ref_in * n;
        if (vco < VCO_LO) continue;
        if (vco > VCO_HI) break;
        p_hit = 0;
        for (int p = 2; p < 10; p += 2) begin
          sysclk = vco / p;
          if (sysclk >= SYSCLK_LO && sysclk <= SYSCLK_HI && sysclk == target) begin
            p_hit = p;
            break;
          end
        end
        if (p_hit == 0) continue;
        q_hit = 0;
        for (int q = 2; q < 16; q++) begin
          if (vco / q <= AUXCLK_MAX) begin
            q_hit = q;
            break;
          end
        end
        if (q_hit == 0) continue;
        s.found  = 1'b1;
        s.div_m  = pds_pkg::M_W'(m);
        s.mult_n = pds_pkg::N_W'(n);
        s.div_p  = pds_pkg::P_W'(p_hit);
        s.p_code = pds_pkg::PC_W'((p_hit - 1) / 2);
        s.div_q  = pds_pkg::Q_W'(q_hit);
        return s;
      end
    end
    return s;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    pll_setting_t exp_s;
    if (rst) begin
      hse_hz <= pds_pkg::HSE_RESET;
      hsi_hz <= pds_pkg::HSI_RESET;
      settings_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == pds_pkg::CFG_HSE) hse_hz <= cfg_data;
        else hsi_hz <= cfg_data;
      end
      if (req.valid && req.ready) begin
        settings_due.push_back(search_dividers(req.source_is_hse ? hse_hz : hsi_hz,
                                               req.target_frequency));
      end
      if (rsp.valid && rsp.ready) begin
        if (settings_due.size() == 0) begin
          $error("response transfer with no request outstanding");
          mismatches++;
        end else begin
          exp_s = settings_due.pop_front();
          check_field("found",  exp_s.found,  rsp.found);
          check_field("div_m",  exp_s.div_m,  rsp.div_m);
          check_field("mult_n", exp_s.mult_n, rsp.mult_n);
          check_field("div_p",  exp_s.div_p,  rsp.div_p);
          check_field("p_code", exp_s.p_code, rsp.p_code);
          check_field("div_q",  exp_s.div_q,  rsp.div_q);
        end
      end
    end
    pending <= settings_due.size();
    fails   <= mismatches;
  end

endmodule

### verif/tb_pll_divider_search_unit.sv
// tb_pll_divider_search_unit: stimulus, handshake pacing and verdict for the
// PLL divider search unit. Depends on pds_pkg, pds_if and pds_search_checker.
module tb_pll_divider_search_unit;

  localparam int             CYCLE_LIMIT   = 6000000;
  localparam int             DRAIN_CYCLES  = 200;
  localparam int             IDLE_CYCLES   = 16;
  localparam int             RANDOM_PHASES = 5;
  localparam int             PHASE_ITEMS   = 16;
  localparam pds_pkg::freq_t FREQ_ALL_ONES = '1;
  localparam pds_pkg::tgt_t  TGT_ALL_ONES  = '1;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_EVERY8, READY_MOSTLY} stall_mode_t;

  logic           clk;
  logic           rst;
  logic           cfg_we;
  logic           cfg_index;
  pds_pkg::freq_t cfg_data;
  int             fails;
  int             pending;
  int             cycle_cnt;
  int             burst_left;
  pds_pkg::freq_t hse_now;
  pds_pkg::freq_t hsi_now;

  pds_req_if req_ch ();
  pds_rsp_if rsp_ch ();

  pll_divider_search_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pds_search_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  // response side back-pressure
  initial begin
    stall_mode_t mode;
    int          mode_left;
    int          tick;
    rsp_ch.ready = 1'b0;
    mode = READY_ALWAYS;
    mode_left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 400);
      end
      mode_left--;
      tick++;
      case (mode)
        READY_ALWAYS: rsp_ch.ready <= 1'b1;
        READY_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
        READY_EVERY8: rsp_ch.ready <= (tick % 8 == 0);
        default:      rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // target reachable from osc_hz through some random M, N, P, else a random in-range target
  function automatic pds_pkg::tgt_t reachable_target(pds_pkg::freq_t osc_hz);
    logic [63:0] ref_in;
    logic [63:0] vco;
    logic [63:0] sysclk;
    for (int tries = 0; tries < 400; tries++) begin
      ref_in = osc_hz / $urandom_range(2, 63);
      if (ref_in < pds_pkg::FIN_MIN || ref_in > pds_pkg::FIN_MAX) continue;
      vco = ref_in * $urandom_range(50, 432);
      sysclk = vco / (2 * $urandom_range(1, 4));
      if (vco >= pds_pkg::VCO_MIN && vco <= pds_pkg::VCO_MAX &&
          sysclk >= pds_pkg::TGT_MIN && sysclk <= pds_pkg::TGT_MAX)
        return pds_pkg::tgt_t'(sysclk);
    end
    return pds_pkg::tgt_t'($urandom_range(24000000, 100000000));
  endfunction

  task automatic send_request(input logic use_hse, input pds_pkg::tgt_t target);
    int gap;
    req_ch.valid <= 1'b1;
    req_ch.source_is_hse <= use_hse;
    req_ch.target_frequency <= target;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 5);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 3000) : $urandom_range(0, 12);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle(input int extra);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_oscillators(input pds_pkg::freq_t hse_hz, input pds_pkg::freq_t hsi_hz);
    cfg_we <= 1'b1;
    cfg_index <= pds_pkg::CFG_HSE;
    cfg_data <= hse_hz;
    @(posedge clk);
    cfg_index <= pds_pkg::CFG_HSI;
    cfg_data <= hsi_hz;
    @(posedge clk);
    cfg_we <= 1'b0;
    hse_now = hse_hz;
    hsi_now = hsi_hz;
    @(posedge clk);
  endtask

  function automatic pds_pkg::freq_t pick_oscillator();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: return pds_pkg::freq_t'(8000000);
      1: return pds_pkg::freq_t'(12000000);
      2: return pds_pkg::freq_t'(25000000);
      3: return pds_pkg::freq_t'(26000000);
      4: return pds_pkg::freq_t'($urandom);
      default: return pds_pkg::freq_t'($urandom_range(1, 50000000));
    endcase
  endfunction

  function automatic pds_pkg::tgt_t pick_target(pds_pkg::freq_t osc_hz);
    int            kind;
    pds_pkg::tgt_t hit;
    kind = $urandom_range(0, 99);
    hit = reachable_target(osc_hz);
    if (kind < 60) return hit;
    if (kind < 72) return ($urandom_range(0, 1) != 0) ? hit + 1'b1 : hit - 1'b1;
    if (kind < 87) return pds_pkg::tgt_t'($urandom_range(24000000, 100000000));
    return pds_pkg::tgt_t'($urandom);
  endfunction

  initial begin
    logic use_hse;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = pds_pkg::CFG_HSE;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.source_is_hse = 1'b0;
    req_ch.target_frequency = '0;
    burst_left = 0;
    hse_now = pds_pkg::HSE_RESET;
    hsi_now = pds_pkg::HSI_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset oscillator values, target range edges
    send_request(1'b1, pds_pkg::tgt_t'(84000000));
    send_request(1'b0, pds_pkg::tgt_t'(84000000));
    send_request(1'b1, pds_pkg::tgt_t'(84000001));
    send_request(1'b0, '0);
    send_request(1'b1, pds_pkg::tgt_t'(24000000));
    send_request(1'b0, pds_pkg::tgt_t'(100000000));
    send_request(1'b1, pds_pkg::tgt_t'(23999999));
    send_request(1'b0, pds_pkg::tgt_t'(100000001));
    send_request(1'b1, TGT_ALL_ONES);
    send_request(1'b0, pds_pkg::tgt_t'(48000000));
    send_request(1'b1, reachable_target(hse_now));
    send_request(1'b0, reachable_target(hsi_now));
    wait_idle(IDLE_CYCLES);

    // smallest and largest legal oscillators
    set_oscillators(pds_pkg::freq_t'(1), pds_pkg::freq_t'(50000000));
    send_request(1'b1, pds_pkg::tgt_t'(48000000));
    send_request(1'b0, reachable_target(hsi_now));
    send_request(1'b0, pds_pkg::tgt_t'(100000000));
    wait_idle(IDLE_CYCLES);

    // zero and all-ones registers
    set_oscillators('0, FREQ_ALL_ONES);
    send_request(1'b1, pds_pkg::tgt_t'(50000000));
    send_request(1'b0, reachable_target(hsi_now));
    send_request(1'b0, TGT_ALL_ONES);
    wait_idle(IDLE_CYCLES);

    // M = 2 lands exactly on the lower and upper reference bounds
    set_oscillators(pds_pkg::freq_t'(1900000), pds_pkg::freq_t'(4200000));
    send_request(1'b1, reachable_target(hse_now));
    send_request(1'b0, reachable_target(hsi_now));
    send_request(1'b0, pds_pkg::tgt_t'(25000000));
    wait_idle(IDLE_CYCLES);

    // HSI too slow for any M
    set_oscillators(pds_pkg::freq_t'(50000000), pds_pkg::freq_t'(950000));
    send_request(1'b0, pds_pkg::tgt_t'(84000000));
    send_request(1'b1, reachable_target(hse_now));
    wait_idle(IDLE_CYCLES);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_oscillators(pick_oscillator(), pick_oscillator());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        use_hse = 1'($urandom_range(0, 1));
        send_request(use_hse, pick_target(use_hse ? hse_now : hsi_now));
      end
      wait_idle(IDLE_CYCLES);
    end

    wait_idle(DRAIN_CYCLES);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### pll_divider_search_unit.f
src/pds_pkg.sv
src/pds_if.sv
src/pds_serial_div.sv
src/pds_search_ctrl.sv
src/pll_divider_search_unit.sv
src/pds_checker.sv
verif/pds_search_checker.sv
verif/tb_pll_divider_search_unit.sv
